// ----- src/ntm_pkg.sv -----
// ----------------------------------------------------------------------------
// ntm_pkg
// shared constants, thermistor table, controller states and command structs
// ----------------------------------------------------------------------------
`default_nettype none

package ntm_pkg;

    // channel store
    localparam int CHANNELS = 4;

    // field widths
    localparam int CH_W     = 2;
    localparam int MV_W     = 12;
    localparam int PU_W     = 16;
    localparam int MG_W     = 8;
    localparam int RES_W    = 24;
    localparam int TEMP_W   = 11;
    localparam int CNT_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULLUP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'b1;

    // configuration reset values
    localparam logic [PU_W-1:0] PULLUP_RST = 16'd10000;
    localparam logic [MG_W-1:0] MARGIN_RST = 8'd20;

    // resistance table
    localparam int LUT_N     = 19;
    localparam int LUT_START = -100;
    localparam int LUT_STEP  = 50;
    localparam int K_W       = 5;
    localparam int OHM_W     = 16;

    // serial divider
    localparam int NUM_W     = MV_W + PU_W + 1;
    localparam int DIVR_W    = 14;
    localparam int STEP_W    = 5;
    localparam int INT_NUM_W = 20;
    localparam int INT_Q_W   = 6;
    localparam logic [STEP_W-1:0] RES_STEPS = STEP_W'(NUM_W);
    localparam logic [STEP_W-1:0] INT_STEPS = STEP_W'(INT_Q_W);

    localparam logic [RES_W-1:0]  RES_MAX = '1;
    localparam logic [TEMP_W-1:0] TEMP_LO = TEMP_W'(LUT_START);
    localparam logic [TEMP_W-1:0] TEMP_HI = TEMP_W'(LUT_START + (LUT_N - 1) * LUT_STEP);

    // thermistor resistance at each 5 C point, descending
    function automatic logic [OHM_W-1:0] ntm_ohm(input logic [K_W-1:0] idx);
        logic [OHM_W-1:0] r;
        case (idx)
            5'd0:    r = 16'd58280;
            5'd1:    r = 16'd44034;
            5'd2:    r = 16'd33626;
            5'd3:    r = 16'd25928;
            5'd4:    r = 16'd20177;
            5'd5:    r = 16'd15840;
            5'd6:    r = 16'd12537;
            5'd7:    r = 16'd10000;
            5'd8:    r = 16'd8037;
            5'd9:    r = 16'd6507;
            5'd10:   r = 16'd5302;
            5'd11:   r = 16'd4349;
            5'd12:   r = 16'd3588;
            5'd13:   r = 16'd2979;
            5'd14:   r = 16'd2486;
            5'd15:   r = 16'd2086;
            5'd16:   r = 16'd1760;
            5'd17:   r = 16'd1492;
            5'd18:   r = 16'd1270;
            default: r = '0;
        endcase
        return r;
    endfunction

    // temperature at the upper-resistance end of segment k
    function automatic logic [TEMP_W-1:0] ntm_base(input logic [K_W-1:0] k);
        return TEMP_W'(LUT_START + (int'(k) - 1) * LUT_STEP);
    endfunction

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RDIV,
        S_RWAIT,
        S_SEARCH,
        S_ISET,
        S_IDIV,
        S_IWAIT,
        S_STORE,
        S_OUT
    } t_ntm_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_res;
        logic res_take;
        logic search;
        logic int_set;
        logic div_int;
        logic int_take;
        logic store;
        logic out_load;
    } t_ntm_cmd;

    typedef struct packed {
        logic fault;
        logic clamp;
        logic div_idle;
        logic out_block;
    } t_ntm_sts;

endpackage

`default_nettype wire

// ----- src/ntm_in_if.sv -----
// ----------------------------------------------------------------------------
// ntm_in_if
// sample request channel: channel number, divider voltage, supply voltage
// ----------------------------------------------------------------------------
`default_nettype none

interface ntm_in_if;
    import ntm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic [MV_W-1:0]   sample_mv;
    logic [MV_W-1:0]   supply_mv;

    modport source (output valid, output channel, output sample_mv, output supply_mv,
                    input ready);
    modport sink   (input valid, input channel, input sample_mv, input supply_mv,
                    output ready);
endinterface

`default_nettype wire

// ----- src/ntm_out_if.sv -----
// ----------------------------------------------------------------------------
// ntm_out_if
// result request channel: resistance, temperature and channel summary
// ----------------------------------------------------------------------------
`default_nettype none

interface ntm_out_if;
    import ntm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic [RES_W-1:0]  resistance_ohm;
    logic [TEMP_W-1:0] temp_tenths_c;
    logic              temp_valid;
    logic [TEMP_W-1:0] max_temp_tenths_c;
    logic              max_valid;
    logic [CNT_W-1:0]  valid_count;

    modport source (output valid, output out_channel, output resistance_ohm,
                    output temp_tenths_c, output temp_valid, output max_temp_tenths_c,
                    output max_valid, output valid_count, input ready);
    modport sink   (input valid, input out_channel, input resistance_ohm,
                    input temp_tenths_c, input temp_valid, input max_temp_tenths_c,
                    input max_valid, input valid_count, output ready);
endinterface

`default_nettype wire

// ----- src/ntc_thermistor_temperature_monitor.sv -----
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_monitor
// ntc divider voltage to resistance and 0.1 C temperature, four channel monitor
// ----------------------------------------------------------------------------
// Each request carries a channel number, the divider midpoint voltage and the
// supply voltage in mV. A sample within fault_margin_mv of ground or of the
// supply marks the channel shorted or open (resistance 0, temperature invalid).
// Otherwise the resistance round(pullup_ohm * v / (supply - v)), saturated at
// 24 bits, is located in a 19-point table (-10 C to +80 C in 5 C steps,
// clamped at both ends) and linearly interpolated to 0.1 C. The channel's
// temperature and valid flag are stored (cleared by reset); every result also
// reports the hottest valid temperature and the number of valid channels. One
// request is processed at a time: a valid sample's processing time is set
// mostly by the shared one-bit-per-cycle divider (29 steps for the
// resistance, 6 for the interpolation); a sample clamped at a table end still
// needs the resistance division but skips the interpolation, and a faulted
// one skips both divisions. The next request is accepted the cycle after the
// result is loaded. The result sits in an output register, so a new request
// is accepted while the previous result waits. Configuration writes take
// effect at once and are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_thermistor_temperature_monitor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ntm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ntm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ntm_in_if.sink                              i_in,
    ntm_out_if.source                           o_out
);
    import ntm_pkg::*;

    t_ntm_cmd w_cmd;
    t_ntm_sts w_sts;
    logic     w_in_ready;

    // sequencer: one state per step of the sample pipeline
    ntm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // math, channel store and result register
    ntm_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_channel           (i_in.channel),
        .i_sample_mv         (i_in.sample_mv),
        .i_supply_mv         (i_in.supply_mv),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_out_channel       (o_out.out_channel),
        .o_resistance_ohm    (o_out.resistance_ohm),
        .o_temp_tenths_c     (o_out.temp_tenths_c),
        .o_temp_valid        (o_out.temp_valid),
        .o_max_temp_tenths_c (o_out.max_temp_tenths_c),
        .o_max_valid         (o_out.max_valid),
        .o_valid_count       (o_out.valid_count)
    );

endmodule

`default_nettype wire

// ----- src/ntm_div.sv -----
// ----------------------------------------------------------------------------
// ntm_div
// restoring divider, one quotient bit per cycle, preloadable partial remainder
// ----------------------------------------------------------------------------
`default_nettype none

module ntm_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ntm_pkg::DIVR_W-1:0]  i_rem0,
    input  wire logic [ntm_pkg::NUM_W-1:0]   i_dividend,
    input  wire logic [ntm_pkg::DIVR_W-1:0]  i_divisor,
    input  wire logic [ntm_pkg::STEP_W-1:0]  i_steps,
    output logic                             o_idle,
    output logic [ntm_pkg::NUM_W-1:0]        o_quot
);
    import ntm_pkg::*;

    logic [STEP_W-1:0] r_cnt,  n_cnt;
    logic [DIVR_W-1:0] r_rem,  n_rem;
    logic [DIVR_W-1:0] r_dvs;
    logic [NUM_W-1:0]  r_quo,  n_quo;
    logic [DIVR_W:0]   w_shift;
    logic [DIVR_W:0]   w_diff;
    logic              w_ge;

    // dividend bits shift out the top, quotient bits shift in at the bottom
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = w_shift >= {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[DIVR_W-1:0] : w_shift[DIVR_W-1:0];
        n_quo   = {r_quo[NUM_W-2:0], w_ge};
        n_cnt   = r_cnt - STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_idle = (r_cnt == '0);
    assign o_quot = r_quo;

endmodule

`default_nettype wire

// ----- src/ntm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ntm_ctrl
// sequencer for one sample: resistance, table search, interpolation, store
// ----------------------------------------------------------------------------
`default_nettype none

module ntm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ntm_pkg::t_ntm_sts i_sts,
    output ntm_pkg::t_ntm_cmd      o_cmd
);
    import ntm_pkg::*;

    t_ntm_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL;
            S_MUL:    n_state = i_sts.fault ? S_STORE : S_RDIV;
            S_RDIV:   n_state = S_RWAIT;
            S_RWAIT:  if (i_sts.div_idle) n_state = S_SEARCH;
            S_SEARCH: n_state = i_sts.clamp ? S_STORE : S_ISET;
            S_ISET:   n_state = S_IDIV;
            S_IDIV:   n_state = S_IWAIT;
            S_IWAIT:  if (i_sts.div_idle) n_state = S_STORE;
            S_STORE:  n_state = S_OUT;
            S_OUT:    if (!i_sts.out_block) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_MUL:    o_cmd.mul      = 1'b1;
            S_RDIV:   o_cmd.div_res  = 1'b1;
            S_RWAIT:  o_cmd.res_take = i_sts.div_idle;
            S_SEARCH: o_cmd.search   = 1'b1;
            S_ISET:   o_cmd.int_set  = 1'b1;
            S_IDIV:   o_cmd.div_int  = 1'b1;
            S_IWAIT:  o_cmd.int_take = i_sts.div_idle;
            S_STORE:  o_cmd.store    = 1'b1;
            S_OUT:    o_cmd.out_load = !i_sts.out_block;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/ntm_dpath.sv -----
// ----------------------------------------------------------------------------
// ntm_dpath
// datapath: config registers, resistance and interpolation math, channel store
// ----------------------------------------------------------------------------
`default_nettype none

module ntm_dpath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ntm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ntm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [ntm_pkg::CH_W-1:0]       i_channel,
    input  wire logic [ntm_pkg::MV_W-1:0]       i_sample_mv,
    input  wire logic [ntm_pkg::MV_W-1:0]       i_supply_mv,
    input  wire ntm_pkg::t_ntm_cmd              i_cmd,
    output ntm_pkg::t_ntm_sts                   o_sts,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [ntm_pkg::CH_W-1:0]            o_out_channel,
    output logic [ntm_pkg::RES_W-1:0]           o_resistance_ohm,
    output logic [ntm_pkg::TEMP_W-1:0]          o_temp_tenths_c,
    output logic                                o_temp_valid,
    output logic [ntm_pkg::TEMP_W-1:0]          o_max_temp_tenths_c,
    output logic                                o_max_valid,
    output logic [ntm_pkg::CNT_W-1:0]           o_valid_count
);
    import ntm_pkg::*;

    // configuration
    logic [PU_W-1:0]   r_pullup;
    logic [MG_W-1:0]   r_margin;

    // working registers
    logic [CH_W-1:0]   r_ch;
    logic [MV_W-1:0]   r_v;
    logic [MV_W-1:0]   r_sup;
    logic [NUM_W-1:0]  r_num;
    logic [RES_W-1:0]  r_res;
    logic [TEMP_W-1:0] r_temp;
    logic              r_valid;
    logic [K_W-1:0]    r_k;
    logic [DIVR_W-1:0] r_span;

    // channel store
    logic [TEMP_W-1:0] r_ch_temp  [CHANNELS];
    logic              r_ch_valid [CHANNELS];

    // result register
    logic              r_out_valid;
    logic [CH_W-1:0]   r_o_ch;
    logic [RES_W-1:0]  r_o_res;
    logic [TEMP_W-1:0] r_o_temp;
    logic              r_o_tvalid;
    logic [TEMP_W-1:0] r_o_max;
    logic              r_o_any;
    logic [CNT_W-1:0]  r_o_cnt;

    logic              w_fault;
    logic [MV_W-1:0]   w_d;
    logic [PU_W+MV_W-1:0] w_prod;
    logic              w_lo_clamp;
    logic              w_hi_clamp;
    logic [K_W-1:0]    w_k;
    logic [OHM_W-1:0]  w_hi;
    logic [OHM_W-1:0]  w_lo;
    logic [DIVR_W-1:0] w_span;
    logic [DIVR_W-1:0] w_diff;
    logic [INT_NUM_W-1:0] w_int_num;
    logic              w_div_start;
    logic [DIVR_W-1:0] w_div_rem0;
    logic [NUM_W-1:0]  w_div_dvd;
    logic [DIVR_W-1:0] w_div_dvs;
    logic [STEP_W-1:0] w_div_steps;
    logic              w_div_idle;
    logic [NUM_W-1:0]  w_quot;
    logic [TEMP_W-1:0] w_max;
    logic              w_any;
    logic [CNT_W-1:0]  w_cnt;

    // open / short test; v >= sup - margin written as v + margin >= sup
    always_comb begin
        w_fault = (r_v <= MV_W'(r_margin))
               || (({1'b0, r_v} + (MV_W+1)'(r_margin)) >= {1'b0, r_sup});
        w_d     = r_sup - r_v;
        w_prod  = r_pullup * r_v;
    end

    // table search over the constant breakpoints
    always_comb begin
        w_lo_clamp = r_res >= RES_W'(ntm_ohm(K_W'(0)));
        w_hi_clamp = r_res <= RES_W'(ntm_ohm(K_W'(LUT_N - 1)));
        w_k = K_W'(LUT_N - 1);
        for (int j = LUT_N - 1; j >= 1; j--) begin
            if (r_res > RES_W'(ntm_ohm(K_W'(j)))) w_k = K_W'(j);
        end
    end

    // segment span and rounded interpolation numerator
    always_comb begin
        w_hi      = ntm_ohm(r_k - K_W'(1));
        w_lo      = ntm_ohm(r_k);
        w_span    = DIVR_W'(w_hi - w_lo);
        w_diff    = DIVR_W'(w_hi - r_res[OHM_W-1:0]);
        w_int_num = INT_NUM_W'(w_diff * INT_NUM_W'(LUT_STEP)) + INT_NUM_W'(w_span >> 1);
    end

    // divider operand select
    always_comb begin
        w_div_start = i_cmd.div_res || i_cmd.div_int;
        if (i_cmd.div_int) begin
            w_div_rem0  = r_num[INT_NUM_W-1:INT_Q_W];
            w_div_dvd   = {r_num[INT_Q_W-1:0], (NUM_W-INT_Q_W)'(0)};
            w_div_dvs   = r_span;
            w_div_steps = INT_STEPS;
        end else begin
            w_div_rem0  = '0;
            w_div_dvd   = r_num;
            w_div_dvs   = DIVR_W'(w_d);
            w_div_steps = RES_STEPS;
        end
    end

    ntm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem0     (w_div_rem0),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .i_steps    (w_div_steps),
        .o_idle     (w_div_idle),
        .o_quot     (w_quot)
    );

    // hottest valid channel and valid count
    always_comb begin
        w_max = '0;
        w_any = 1'b0;
        w_cnt = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (r_ch_valid[i]) begin
                w_cnt = w_cnt + CNT_W'(1);
                if (!w_any || ($signed(r_ch_temp[i]) > $signed(w_max))) begin
                    w_max = r_ch_temp[i];
                end
                w_any = 1'b1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pullup <= PULLUP_RST;
            r_margin <= MARGIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PULLUP: r_pullup <= i_cfg_data[PU_W-1:0];
                CFG_MARGIN: r_margin <= i_cfg_data[MG_W-1:0];
                default:    r_pullup <= r_pullup;
            endcase
        end
    end

    // sample math
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch  <= i_channel;
            r_v   <= i_sample_mv;
            r_sup <= i_supply_mv;
        end
        if (i_cmd.mul) begin
            r_num   <= NUM_W'(w_prod) + NUM_W'(w_d >> 1);
            r_res   <= '0;
            r_temp  <= '0;
            r_valid <= !w_fault;
        end
        if (i_cmd.res_take) begin
            r_res <= (|w_quot[NUM_W-1:RES_W]) ? RES_MAX : w_quot[RES_W-1:0];
        end
        if (i_cmd.search) begin
            r_k <= w_k;
            if (w_lo_clamp) begin
                r_temp <= TEMP_LO;
            end else if (w_hi_clamp) begin
                r_temp <= TEMP_HI;
            end
        end
        if (i_cmd.int_set) begin
            r_num  <= NUM_W'(w_int_num);
            r_span <= w_span;
        end
        if (i_cmd.int_take) begin
            r_temp <= ntm_base(r_k) + TEMP_W'(w_quot[INT_Q_W-1:0]);
        end
    end

    // channel store, out-of-range channels leave it untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_ch_temp[i]  <= '0;
                r_ch_valid[i] <= 1'b0;
            end
        end else if (i_cmd.store) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (int'(r_ch) == i) begin
                    r_ch_temp[i]  <= r_temp;
                    r_ch_valid[i] <= r_valid;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_ch     <= r_ch;
            r_o_res    <= r_res;
            r_o_temp   <= r_temp;
            r_o_tvalid <= r_valid;
            r_o_max    <= w_max;
            r_o_any    <= w_any;
            r_o_cnt    <= w_cnt;
        end
    end

    always_comb begin
        o_sts.fault     = w_fault;
        o_sts.clamp     = w_lo_clamp || w_hi_clamp;
        o_sts.div_idle  = w_div_idle;
        o_sts.out_block = r_out_valid && !i_out_ready;
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_channel       = r_o_ch;
    assign o_resistance_ohm    = r_o_res;
    assign o_temp_tenths_c     = r_o_temp;
    assign o_temp_valid        = r_o_tvalid;
    assign o_max_temp_tenths_c = r_o_max;
    assign o_max_valid         = r_o_any;
    assign o_valid_count       = r_o_cnt;

endmodule

`default_nettype wire
